[rtl/osm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants for the order statistic multiset
// Key and count widths, action and status codes, the FSM state type and
// the command word that the controller sends down the cell row.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int STS_W    = 2;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [ACT_W-1:0]           act_t;
    typedef logic [STS_W-1:0]           sts_t;

    localparam act_t ACT_INSERT = 3'd0;
    localparam act_t ACT_DELETE = 3'd1;
    localparam act_t ACT_RANK   = 3'd2;
    localparam act_t ACT_KTH    = 3'd3;
    localparam act_t ACT_PRED   = 3'd4;
    localparam act_t ACT_SUCC   = 3'd5;

    localparam sts_t STS_OK    = 2'd0;
    localparam sts_t STS_NONE  = 2'd1;
    localparam sts_t STS_FULL  = 2'd2;
    localparam sts_t STS_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_SEL   = 4'b0100,
        S_APPLY = 4'b1000
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic sel_en;
        logic ins_en;
        logic del_en;
        logic pick_kth;
        logic pick_pred;
        logic pick_succ;
        logic pick_del;
    } cell_cmd_t;

endpackage

[rtl/order_statistic_multiset_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_core: sorted multiset with rank and select
// Keeps up to CAPACITY signed keys in a row of cells in ascending order and
// answers insert, delete, rank, kth, predecessor and successor words.
// ----------------------------------------------------------------------------
// Each input word is accepted in S_IDLE; in S_CMP every cell compares its
// key against the operand, S_SEL picks the target cell and encodes the rank
// from the row of compare flags, and S_APPLY shifts the row and loads the
// result word. The next word is taken in the cycle after that,
// as long as the output register is free or being emptied; a held result
// word holds the last step until it drains. No clearing pass after reset.
// ----------------------------------------------------------------------------
module order_statistic_multiset_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  osm_pkg::act_t         action,
    input  osm_pkg::key_t         key,
    input  osm_pkg::cnt_t         position,
    output logic                  out_valid,
    input  logic                  out_stall,
    output osm_pkg::key_t         result_value,
    output osm_pkg::cnt_t         result_rank,
    output osm_pkg::sts_t         status,
    output osm_pkg::cnt_t         element_count
);

    localparam int CAP = osm_pkg::CAPACITY;

    osm_pkg::state_t    state_reg, state_next;
    osm_pkg::act_t      act_reg;
    osm_pkg::key_t      key_reg;
    osm_pkg::cnt_t      pos_reg;
    osm_pkg::cnt_t      pos_m1;
    osm_pkg::cnt_t      count_reg, count_next;
    osm_pkg::cnt_t      below_reg;
    osm_pkg::cnt_t      below_w;
    osm_pkg::cell_cmd_t cmd;

    logic               out_valid_reg;
    osm_pkg::key_t      value_reg, value_next;
    osm_pkg::cnt_t      rank_reg, rank_next;
    osm_pkg::sts_t      status_reg, status_next;
    osm_pkg::cnt_t      ecount_reg;

    osm_pkg::key_t      cell_key [CAP];
    logic [CAP-1:0]     cell_lt;
    logic [CAP-1:0]     cell_le;
    logic [CAP-1:0]     cell_sel;
    logic [CAP-1:0]     cell_occ;
    logic [CAP-1:0]     cell_kth;

    osm_pkg::key_t      pick_value;
    logic               any_sel;
    logic               in_fire;
    logic               out_free;
    logic               fire;
    logic               do_ins;
    logic               do_del;

    assign in_fire  = in_valid && (state_reg == osm_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = (state_reg == osm_pkg::S_APPLY) && out_free;
    assign pos_m1   = pos_reg - osm_pkg::CNT_W'(1);

    // per-slot occupancy and kth target
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            cell_occ[i] = osm_pkg::CNT_W'(i) < count_reg;
            cell_kth[i] = osm_pkg::CNT_W'(i) == pos_m1;
        end
    end

    // gather the picked cell
    always_comb
    begin
        pick_value = '0;
        for (int i = 0; i < CAP; i++)
        begin
            pick_value = pick_value | (cell_key[i] & {osm_pkg::KEY_BITS{cell_sel[i]}});
        end
        any_sel = |cell_sel;
    end

    // resolve the word
    always_comb
    begin
        value_next  = '0;
        rank_next   = '0;
        status_next = osm_pkg::STS_OK;
        count_next  = count_reg;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        case (act_reg)
            osm_pkg::ACT_INSERT:
            begin
                if (count_reg == osm_pkg::CNT_W'(CAP))
                begin
                    status_next = osm_pkg::STS_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + osm_pkg::CNT_W'(1);
                end
            end
            osm_pkg::ACT_DELETE:
            begin
                if (any_sel)
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - osm_pkg::CNT_W'(1);
                end
                else
                begin
                    status_next = osm_pkg::STS_NONE;
                end
            end
            osm_pkg::ACT_RANK:
            begin
                rank_next = below_reg + osm_pkg::CNT_W'(1);
            end
            osm_pkg::ACT_KTH:
            begin
                if (pos_reg == '0 || pos_reg > count_reg)
                begin
                    status_next = osm_pkg::STS_RANGE;
                end
                else
                begin
                    value_next = pick_value;
                end
            end
            osm_pkg::ACT_PRED, osm_pkg::ACT_SUCC:
            begin
                if (any_sel)
                begin
                    value_next = pick_value;
                end
                else
                begin
                    status_next = osm_pkg::STS_NONE;
                end
            end
            default:
            begin
                status_next = osm_pkg::STS_OK;
            end
        endcase
    end

    // cell row commands
    always_comb
    begin
        cmd           = '0;
        cmd.cmp_en    = (state_reg == osm_pkg::S_CMP);
        cmd.sel_en    = (state_reg == osm_pkg::S_SEL);
        cmd.pick_kth  = (act_reg == osm_pkg::ACT_KTH);
        cmd.pick_pred = (act_reg == osm_pkg::ACT_PRED);
        cmd.pick_succ = (act_reg == osm_pkg::ACT_SUCC);
        cmd.pick_del  = (act_reg == osm_pkg::ACT_DELETE);
        cmd.ins_en    = fire && do_ins;
        cmd.del_en    = fire && do_del;
    end

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            osm_cell u_cell
            (
                .clk       (clk),
                .cmd       (cmd),
                .op_key    (key_reg),
                .occupied  (cell_occ[g]),
                .kth_hit   (cell_kth[g]),
                .left_key  ((g == 0) ? cell_key[g] : cell_key[(g == 0) ? 0 : g-1]),
                .left_le   ((g == 0) ? 1'b1 : cell_le[(g == 0) ? 0 : g-1]),
                .right_key ((g == CAP-1) ? cell_key[g] : cell_key[(g == CAP-1) ? g : g+1]),
                .right_lt  ((g == CAP-1) ? 1'b0 : cell_lt[(g == CAP-1) ? g : g+1]),
                .key       (cell_key[g]),
                .lt        (cell_lt[g]),
                .le        (cell_le[g]),
                .sel       (cell_sel[g])
            );
        end
    endgenerate

    osm_rank_enc u_rank_enc
    (
        .lt_flags (cell_lt),
        .below    (below_w)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            osm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = osm_pkg::S_CMP;
                end
            end
            osm_pkg::S_CMP:
            begin
                state_next = osm_pkg::S_SEL;
            end
            osm_pkg::S_SEL:
            begin
                state_next = osm_pkg::S_APPLY;
            end
            osm_pkg::S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = osm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = osm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osm_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= action;
            key_reg <= key;
            pos_reg <= position;
        end
        if (state_reg == osm_pkg::S_SEL)
        begin
            below_reg <= below_w;
        end
        if (fire)
        begin
            value_reg  <= value_next;
            rank_reg   <= rank_next;
            status_reg <= status_next;
            ecount_reg <= count_next;
        end
    end

    assign in_stall      = (state_reg != osm_pkg::S_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_value  = value_reg;
    assign result_rank   = rank_reg;
    assign status        = status_reg;
    assign element_count = ecount_reg;

endmodule

[rtl/osm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_cell: one slot of the sorted row
// Holds one key, compares it against the operand, flags itself as the
// picked element and shifts left or right with its neighbors.
// ----------------------------------------------------------------------------
module osm_cell
(
    input  logic               clk,
    input  osm_pkg::cell_cmd_t cmd,
    input  osm_pkg::key_t      op_key,
    input  logic               occupied,
    input  logic               kth_hit,
    input  osm_pkg::key_t      left_key,
    input  logic               left_le,
    input  osm_pkg::key_t      right_key,
    input  logic               right_lt,
    output osm_pkg::key_t      key,
    output logic               lt,
    output logic               le,
    output logic               sel
);

    osm_pkg::key_t key_reg;
    logic          lt_reg;
    logic          le_reg;
    logic          sel_reg;
    logic          sel_next;

    always_comb
    begin
        sel_next = (cmd.pick_kth  & kth_hit)
                 | (cmd.pick_pred & lt_reg & ~right_lt)
                 | (cmd.pick_succ & occupied & ~le_reg & left_le)
                 | (cmd.pick_del  & le_reg & ~lt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            lt_reg <= occupied & (key_reg < op_key);
            le_reg <= occupied & (key_reg <= op_key);
        end
        if (cmd.sel_en)
        begin
            sel_reg <= sel_next;
        end
        // open a gap at the insert point, close it at the delete point
        if (cmd.ins_en)
        begin
            if (!left_le)
            begin
                key_reg <= left_key;
            end
            else if (!le_reg)
            begin
                key_reg <= op_key;
            end
        end
        else if (cmd.del_en && !lt_reg)
        begin
            key_reg <= right_key;
        end
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign le  = le_reg;
    assign sel = sel_reg;

endmodule

[rtl/osm_rank_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_rank_enc: thermometer to count encoder
// Turns the row of less-than flags, a run of ones from slot zero, into the
// number of held elements below the operand.
// ----------------------------------------------------------------------------
module osm_rank_enc
(
    input  logic [osm_pkg::CAPACITY-1:0] lt_flags,
    output osm_pkg::cnt_t                below
);

    logic [osm_pkg::CAPACITY:0] ext;

    always_comb
    begin
        ext   = {1'b0, lt_flags};
        below = '0;
        for (int j = 1; j <= osm_pkg::CAPACITY; j++)
        begin
            if (ext[j-1] && !ext[j])
            begin
                below = below | osm_pkg::CNT_W'(j);
            end
        end
    end

endmodule
